FILE: sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg - barometric sensor compensation package
// Shared types and constants for the compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package bsc_pkg;

    // divider depth in stages, one quotient bit per stage
    localparam int DivLat = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_AC_SIGNED   = 3'd0;
    localparam logic [2:0] CFG_AC_UNSIGNED = 3'd1;
    localparam logic [2:0] CFG_B_M         = 3'd2;
    localparam logic [2:0] CFG_OVERSAMPLE  = 3'd3;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_3038    = 32'd3038;
    localparam logic [31:0] C_M7357   = 32'hFFFF_E343;
    localparam logic [31:0] C_3791    = 32'd3791;
    localparam logic [31:0] C_50000   = 32'd50000;
    localparam logic [31:0] C_32768   = 32'd32768;

    // sideband carried alongside the temperature divider
    typedef struct packed {
        logic [31:0] x1;
        logic [31:0] up;
        logic        neg;
        logic        err;
    } div1_side_t;

    // sideband carried alongside the pressure divider
    typedef struct packed {
        logic [31:0] t;
        logic        big;
        logic        err;
    } div2_side_t;

endpackage
`default_nettype wire

FILE: sv/bsc_sample_if.sv
// ----------------------------------------------------------------------------
// bsc_sample_if - raw reading channel
// Carries one raw temperature and raw pressure pair per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsc_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface
`default_nettype wire

FILE: sv/bsc_result_if.sv
// ----------------------------------------------------------------------------
// bsc_result_if - compensated result channel
// Carries true temperature, true pressure and the divide error flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] true_temperature;
    logic signed [31:0] true_pressure;
    logic               divide_error;
    modport source (output valid, output true_temperature, output true_pressure,
                    output divide_error, input ready);
    modport sink   (input valid, input true_temperature, input true_pressure,
                    input divide_error, output ready);
endinterface
`default_nettype wire

FILE: sv/bsc_cfg_if.sv
// ----------------------------------------------------------------------------
// bsc_cfg_if - configuration write channel
// Carries a register index and write data per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/bsc_udiv.sv
// ----------------------------------------------------------------------------
// bsc_udiv - pipelined unsigned divider
// 32-bit restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module bsc_udiv (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic      [31:0] quo
);

    logic [31:0] rem_reg [bsc_pkg::DivLat];
    logic [31:0] num_reg [bsc_pkg::DivLat];
    logic [31:0] den_reg [bsc_pkg::DivLat];
    logic [31:0] quo_reg [bsc_pkg::DivLat];

    for (genvar k = 0; k < bsc_pkg::DivLat; k++) begin : g_stage
        logic [31:0] rem_in;
        logic [31:0] num_in;
        logic [31:0] den_in;
        logic [31:0] quo_in;
        logic [32:0] trial;
        logic [32:0] diff;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // shift in next numerator bit, subtract if it fits
        assign trial = {rem_in, num_in[31]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= diff[32] ? trial[31:0] : diff[31:0];
                num_reg[k] <= {num_in[30:0], 1'b0};
                den_reg[k] <= den_in;
                quo_reg[k] <= {quo_in[30:0], ~diff[32]};
            end
        end
    end

    assign quo = quo_reg[bsc_pkg::DivLat-1];

endmodule
`default_nettype wire

FILE: sv/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation - barometric temperature/pressure compensation
// Integer datasheet compensation in a 76-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   sample : raw temperature word and raw 24-bit pressure, one per transfer.
//   result : true temperature (0.1 C), true pressure (Pa), divide error.
//   cfg    : index 0..3 selects cal_ac_signed, cal_ac_unsigned, cal_b_m,
//            oversampling; other indexes are dropped. Always ready.
//            Write only while the pipeline is empty.
// Throughput is one reading per cycle while the receiver does not stall.
// From sample transfer to result valid the path runs through the two
// 32-stage dividers (x2 of the temperature path and b7 / b4 of the
// pressure path) and twelve multiply and adjust stages.
// A zero divisor sets divide_error and forces both values to zero.
// Reset empties the pipeline and loads all calibration with zero and
// oversampling with 1. When the receiver stalls the whole pipeline holds,
// the result register keeps its transfer and sample.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module baro_sensor_compensation (
    input  wire logic clk,
    input  wire logic rst_n,
    bsc_sample_if.sink   sample,
    bsc_result_if.source result,
    bsc_cfg_if.sink      cfg
);

    // signed division by 2^n truncating toward zero
    function automatic logic [31:0] sdiv_pow2(input logic [31:0] v, input logic [3:0] n);
        logic [31:0] bias;
        bias = v[31] ? ((32'd1 << n) - 32'd1) : 32'd0;
        return 32'($signed(v + bias) >>> n);
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    logic [47:0] cal_ac_signed_reg;
    logic [47:0] cal_ac_unsigned_reg;
    logic [63:0] cal_b_m_reg;
    logic [1:0]  oss_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_ac_signed_reg   <= '0;
            cal_ac_unsigned_reg <= '0;
            cal_b_m_reg         <= '0;
            oss_reg             <= 2'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bsc_pkg::CFG_AC_SIGNED:   cal_ac_signed_reg   <= cfg.data[47:0];
                bsc_pkg::CFG_AC_UNSIGNED: cal_ac_unsigned_reg <= cfg.data[47:0];
                bsc_pkg::CFG_B_M:         cal_b_m_reg         <= cfg.data;
                bsc_pkg::CFG_OVERSAMPLE:  oss_reg             <= cfg.data[1:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(cal_ac_signed_reg[47:32]);
    assign ac2 = sx16(cal_ac_signed_reg[31:16]);
    assign ac3 = sx16(cal_ac_signed_reg[15:0]);
    assign ac4 = {16'd0, cal_ac_unsigned_reg[47:32]};
    assign ac5 = {16'd0, cal_ac_unsigned_reg[31:16]};
    assign ac6 = {16'd0, cal_ac_unsigned_reg[15:0]};
    assign b1  = sx16(cal_b_m_reg[63:48]);
    assign b2  = sx16(cal_b_m_reg[47:32]);
    assign mc  = sx16(cal_b_m_reg[31:16]);
    assign md  = sx16(cal_b_m_reg[15:0]);

    // global advance: move when the result register is free or taken
    logic en;
    assign en = !result.valid || result.ready;
    assign sample.ready = en;

    // ------------------------------------------------------------------
    // valid bits
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    logic q1_v_reg, q2_v_reg, out_v_reg;
    logic [bsc_pkg::DivLat-1:0] d1_v_reg, d2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            d1_v_reg  <= '0;
            s4_v_reg  <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            p5_v_reg  <= 1'b0;
            d2_v_reg  <= '0;
            q1_v_reg  <= 1'b0;
            q2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= sample.valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            d1_v_reg  <= {d1_v_reg[bsc_pkg::DivLat-2:0], s3_v_reg};
            s4_v_reg  <= d1_v_reg[bsc_pkg::DivLat-1];
            p1_v_reg  <= s4_v_reg;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg;
            p5_v_reg  <= p4_v_reg;
            d2_v_reg  <= {d2_v_reg[bsc_pkg::DivLat-2:0], p5_v_reg};
            q1_v_reg  <= d2_v_reg[bsc_pkg::DivLat-1];
            q2_v_reg  <= q1_v_reg;
            out_v_reg <= q2_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // temperature front end
    logic [15:0] s1_ut_reg;
    logic [31:0] s1_up_reg;
    logic [31:0] s2_prod_reg, s2_up_reg;
    logic [31:0] s3_x1_reg, s3_div_reg, s3_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ut_reg   <= sample.raw_temperature;
            s1_up_reg   <= {8'd0, sample.raw_pressure} >> (4'd8 - {2'd0, oss_reg});
            s2_prod_reg <= ({16'd0, s1_ut_reg} - ac6) * ac5;
            s2_up_reg   <= s1_up_reg;
            s3_x1_reg   <= sdiv_pow2(s2_prod_reg, 4'd15);
            s3_div_reg  <= sdiv_pow2(s2_prod_reg, 4'd15) + md;
            s3_up_reg   <= s2_up_reg;
        end
    end

    // signed x2 = (mc << 11) / div as magnitudes
    logic [31:0] d1_num, d1_den, d1_quo, mc_sh;
    logic        d1_zero;
    assign mc_sh   = mc << 11;
    assign d1_zero = (s3_div_reg == 32'd0);
    assign d1_num  = mc_sh[31] ? -mc_sh : mc_sh;
    assign d1_den  = d1_zero ? 32'd1 : (s3_div_reg[31] ? -s3_div_reg : s3_div_reg);

    bsc_udiv u_div_t (
        .clk (clk),
        .en  (en),
        .num (d1_num),
        .den (d1_den),
        .quo (d1_quo)
    );

    bsc_pkg::div1_side_t side1_reg [bsc_pkg::DivLat];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg[0] <= '{x1: s3_x1_reg, up: s3_up_reg,
                              neg: mc_sh[31] ^ s3_div_reg[31], err: d1_zero};
            for (int k = 1; k < bsc_pkg::DivLat; k++)
            begin
                side1_reg[k] <= side1_reg[k-1];
            end
        end
    end

    bsc_pkg::div1_side_t s1out;
    logic [31:0] x2_t, b5;
    assign s1out = side1_reg[bsc_pkg::DivLat-1];
    assign x2_t  = s1out.neg ? -d1_quo : d1_quo;
    assign b5    = s1out.x1 + x2_t;

    // ------------------------------------------------------------------
    // pressure coefficient stages
    logic [31:0] s4_t_reg, s4_b6_reg, s4_up_reg;
    logic        s4_err_reg;
    logic [31:0] p1_sq_reg, p1_ac2_reg, p1_ac3_reg, p1_t_reg, p1_up_reg;
    logic        p1_err_reg;
    logic [31:0] p2_b2_reg, p2_b1_reg, p2_x2_reg, p2_x1_reg, p2_t_reg, p2_up_reg;
    logic        p2_err_reg;
    logic [31:0] p3_b3_reg, p3_x3_reg, p3_t_reg, p3_up_reg;
    logic        p3_err_reg;
    logic [31:0] p4_b4_reg, p4_d_reg, p4_t_reg;
    logic        p4_err_reg;
    logic [31:0] p5_b7_reg, p5_b4_reg, p5_t_reg;
    logic        p5_err_reg;

    logic [31:0] p2_b6sq, p3_x3a, p3_sh;
    assign p2_b6sq = asr(p1_sq_reg, 5'd12);
    assign p3_x3a  = asr(p2_b2_reg, 5'd11) + p2_x2_reg;
    assign p3_sh   = ((ac1 << 2) + p3_x3a) << oss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_t_reg   <= sdiv_pow2(b5 + 32'd8, 4'd4);
            s4_b6_reg  <= b5 - bsc_pkg::B6_OFFSET;
            s4_up_reg  <= s1out.up;
            s4_err_reg <= s1out.err;

            p1_sq_reg  <= s4_b6_reg * s4_b6_reg;
            p1_ac2_reg <= ac2 * s4_b6_reg;
            p1_ac3_reg <= ac3 * s4_b6_reg;
            p1_t_reg   <= s4_t_reg;
            p1_up_reg  <= s4_up_reg;
            p1_err_reg <= s4_err_reg;

            p2_b2_reg  <= b2 * p2_b6sq;
            p2_b1_reg  <= b1 * p2_b6sq;
            p2_x2_reg  <= asr(p1_ac2_reg, 5'd11);
            p2_x1_reg  <= asr(p1_ac3_reg, 5'd13);
            p2_t_reg   <= p1_t_reg;
            p2_up_reg  <= p1_up_reg;
            p2_err_reg <= p1_err_reg;

            p3_b3_reg  <= asr(p3_sh + 32'd2, 5'd2);
            p3_x3_reg  <= asr(p2_x1_reg + asr(p2_b1_reg, 5'd16) + 32'd2, 5'd2);
            p3_t_reg   <= p2_t_reg;
            p3_up_reg  <= p2_up_reg;
            p3_err_reg <= p2_err_reg;

            p4_b4_reg  <= (ac4 * (p3_x3_reg + bsc_pkg::C_32768)) >> 15;
            p4_d_reg   <= p3_up_reg - p3_b3_reg;
            p4_t_reg   <= p3_t_reg;
            p4_err_reg <= p3_err_reg;

            p5_b7_reg  <= p4_d_reg * (bsc_pkg::C_50000 >> oss_reg);
            p5_b4_reg  <= p4_b4_reg;
            p5_t_reg   <= p4_t_reg;
            p5_err_reg <= p4_err_reg || (p4_b4_reg == 32'd0);
        end
    end

    // unsigned b7 / b4, pre-doubled when b7 fits
    logic [31:0] d2_num, d2_den, d2_quo;
    assign d2_num = p5_b7_reg[31] ? p5_b7_reg : (p5_b7_reg << 1);
    assign d2_den = (p5_b4_reg == 32'd0) ? 32'd1 : p5_b4_reg;

    bsc_udiv u_div_p (
        .clk (clk),
        .en  (en),
        .num (d2_num),
        .den (d2_den),
        .quo (d2_quo)
    );

    bsc_pkg::div2_side_t side2_reg [bsc_pkg::DivLat];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg[0] <= '{t: p5_t_reg, big: p5_b7_reg[31], err: p5_err_reg};
            for (int k = 1; k < bsc_pkg::DivLat; k++)
            begin
                side2_reg[k] <= side2_reg[k-1];
            end
        end
    end

    bsc_pkg::div2_side_t s2out;
    logic [31:0] p_raw, p_hi;
    assign s2out = side2_reg[bsc_pkg::DivLat-1];
    assign p_raw = s2out.big ? (d2_quo << 1) : d2_quo;
    assign p_hi  = asr(p_raw, 5'd8);

    // ------------------------------------------------------------------
    // final pressure correction
    logic [31:0] q1_sq_reg, q1_m_reg, q1_p_reg, q1_t_reg;
    logic        q1_err_reg;
    logic [31:0] q2_m_reg, q2_x2_reg, q2_p_reg, q2_t_reg;
    logic        q2_err_reg;
    logic [31:0] out_t_reg, out_p_reg;
    logic        out_err_reg;
    logic [31:0] q3_p;

    assign q3_p = q2_p_reg + asr(asr(q2_m_reg, 5'd16) + q2_x2_reg + bsc_pkg::C_3791, 5'd4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_sq_reg   <= p_hi * p_hi;
            q1_m_reg    <= bsc_pkg::C_M7357 * p_raw;
            q1_p_reg    <= p_raw;
            q1_t_reg    <= s2out.t;
            q1_err_reg  <= s2out.err;

            q2_m_reg    <= q1_sq_reg * bsc_pkg::C_3038;
            q2_x2_reg   <= asr(q1_m_reg, 5'd16);
            q2_p_reg    <= q1_p_reg;
            q2_t_reg    <= q1_t_reg;
            q2_err_reg  <= q1_err_reg;

            out_t_reg   <= q2_err_reg ? 32'd0 : q2_t_reg;
            out_p_reg   <= q2_err_reg ? 32'd0 : q3_p;
            out_err_reg <= q2_err_reg;
        end
    end

    assign result.valid            = out_v_reg;
    assign result.true_temperature = $signed(out_t_reg);
    assign result.true_pressure    = $signed(out_p_reg);
    assign result.divide_error     = out_err_reg;

endmodule
`default_nettype wire

FILE: sv/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker - port-level checks for baro_sensor_compensation
// Watches the sample and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_t,
    input wire logic [31:0] out_p,
    input wire logic        out_err
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // pipeline takes input exactly when it can advance
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("sample ready does not follow result flow");

    // error results carry zeros
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> (out_t == 32'd0) && (out_p == 32'd0))
        else $error("divide error with nonzero result");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_t     (result.true_temperature),
    .out_p     (result.true_pressure),
    .out_err   (result.divide_error)
);
`default_nettype wire
